@@ src/xpf_pkg.sv @@
// ----------------------------------------------------------------------------
// xpf_pkg
// Shared sizes, types and helpers for the XOR parity recovery core.
// ----------------------------------------------------------------------------
package xpf_pkg;

    localparam int FRAMES    = 1024;
    localparam int WORDS     = 20;
    localparam int ROW_FR    = 4;                  // frames per flag row
    localparam int ROWS      = FRAMES / ROW_FR;
    localparam int PAIRS     = FRAMES / 2;
    localparam int QUADS     = FRAMES / 4;
    localparam int SEQ_W     = $clog2(FRAMES);
    localparam int ROW_W     = $clog2(ROWS);
    localparam int PG_W      = $clog2(PAIRS);
    localparam int QG_W      = $clog2(QUADS);
    localparam int WI_W      = 5;
    localparam int NF_W      = 11;
    localparam int FA_W      = $clog2(FRAMES * WORDS);
    localparam int PA_W      = $clog2(PAIRS * WORDS);
    localparam int QA_W      = $clog2(QUADS * WORDS);
    localparam int J_W       = $clog2(ROW_FR + 1);

    localparam logic [NF_W-1:0] NF_RESET  = NF_W'(1024);
    localparam logic            REQ_MEDIA = 1'b0;
    localparam logic [7:0]      GS_PAIR   = 8'h02;
    localparam logic [7:0]      GS_QUAD   = 8'h04;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_REC
    } t_state;

    // one row of flags covers one quad: four frames, its two pairs, itself
    typedef struct packed {
        logic                qval;
        logic [1:0]          pval;
        logic [ROW_FR-1:0]   done;
    } t_flag_row;

    typedef struct packed {
        logic                fire;
        logic [1:0]          miss_off;
        logic [ROW_FR-1:0]   use_mask;
    } t_rec_chk;

    typedef struct packed {
        logic                we;
        logic [SEQ_W-1:0]    wid;
        logic [WI_W-1:0]     wword;
        logic                re;
        logic [SEQ_W-1:0]    rid;
        logic [WI_W-1:0]     rword;
    } t_fm_cmd;

    typedef struct packed {
        logic                we;
        logic                wquad;
        logic [PG_W-1:0]     wgrp;
        logic [WI_W-1:0]     wword;
        logic                re;
        logic                rquad;
        logic [PG_W-1:0]     rgrp;
        logic [WI_W-1:0]     rword;
    } t_pm_cmd;

    // exactly one member of the group missing -> recoverable
    function automatic t_rec_chk rec_check(input logic valid,
                                           input logic [ROW_FR-1:0] inc,
                                           input logic [ROW_FR-1:0] done);
        t_rec_chk          r;
        logic [ROW_FR-1:0] miss;
        miss       = inc & ~done;
        r.fire     = valid && (miss != '0) && ((miss & (miss - 1'b1)) == '0);
        r.miss_off = miss[3] ? 2'd3 : (miss[2] ? 2'd2 : (miss[1] ? 2'd1 : 2'd0));
        r.use_mask = inc & done;
        return r;
    endfunction

endpackage

@@ src/xor_parity_fec_recovery_core.sv @@
// ----------------------------------------------------------------------------
// xor_parity_fec_recovery_core
// XOR parity erasure recovery: stores frames, forwards them, rebuilds a
// single missing frame of a pair or quad from its parity packet.
// ----------------------------------------------------------------------------
//  channel   signals                                      handshake
//  input     i_req_type i_seq i_group_size i_word_index   start & !busy
//            i_payload_word
//  result    o_frame_seq o_out_word_index o_out_word      o_result_valid strobe
//            o_was_recovered o_last_of_run
//  config    i_cfg_data (n_frames)                        i_cfg_valid & o_cfg_ready
//
//  A word is accepted, then its flag row is read and decided on; its result
//  shows the cycle after. A recovery reads each payload word of the four
//  frames of the row on the single frame store read port, then writes the
//  rebuilt word back, for up to two frames after a media word.
//  After reset a clearing pass zeroes all ROWS (256) flag rows;
//  busy stays high meanwhile. Results cannot be stalled.
// ----------------------------------------------------------------------------
module xor_parity_fec_recovery_core
    import xpf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_req_type,
    input  logic [31:0]       i_seq,
    input  logic [7:0]        i_group_size,
    input  logic [WI_W-1:0]   i_word_index,
    input  logic [63:0]       i_payload_word,
    output logic              o_result_valid,
    output logic [SEQ_W-1:0]  o_frame_seq,
    output logic [WI_W-1:0]   o_out_word_index,
    output logic [63:0]       o_out_word,
    output logic              o_was_recovered,
    output logic              o_last_of_run,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [NF_W-1:0]   i_cfg_data
);

    t_state r_state, n_state;

    // latched request
    logic              r_req_type;
    logic [31:0]       r_seq;
    logic [7:0]        r_group_size;
    logic [WI_W-1:0]   r_word_index;
    logic [63:0]       r_payload_word;

    logic [NF_W-1:0]   r_n_frames;
    logic [ROW_W-1:0]  r_clr_cnt;

    // pending recoveries, pair before quad
    t_rec_chk          r_slot_p, n_slot_p;
    t_rec_chk          r_slot_q, n_slot_q;
    logic [ROW_W-1:0]  r_row, n_row;
    logic              r_half, n_half;
    logic [WI_W-1:0]   r_w, n_w;
    logic [J_W-1:0]    r_j, n_j;
    logic [63:0]       r_acc, n_acc;
    logic              r_rd_act, n_rd_act;
    logic              r_rd_first, n_rd_first;
    logic              r_rd_use, n_rd_use;

    // result register
    logic              r_out_vld, n_out_vld;
    logic [SEQ_W-1:0]  r_out_seq, n_out_seq;
    logic [WI_W-1:0]   r_out_idx, n_out_idx;
    logic [63:0]       r_out_word, n_out_word;
    logic              r_out_rec, n_out_rec;
    logic              r_out_last, n_out_last;

    // memory ports
    t_flag_row         fl_rdata, fl_wdata;
    logic              fl_we;
    logic [ROW_W-1:0]  fl_waddr;
    t_fm_cmd           fm_cmd;
    logic [63:0]       fm_wdata, fm_rdata;
    t_pm_cmd           pm_cmd;
    logic [63:0]       pm_rdata;

    // decisions in ST_LOOK
    logic              in_range, is_last, media_ok, par2_ok, par4_ok, flag_wr;
    logic [NF_W-1:0]   lim;
    logic [ROW_FR-1:0] in_lim, pair_inc, done0, done1, done2;
    logic [1:0]        pv0;
    logic              qv0;
    t_rec_chk          pair_chk, quad_chk, cur;
    logic              cur_quad, acc_sel_last, rec_word_end, rec_last;
    logic [63:0]       acc_in;

    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);

    // ---- request decode against the flag row --------------------------------
    always_comb begin
        lim      = (r_n_frames < NF_W'(FRAMES)) ? r_n_frames : NF_W'(FRAMES);
        in_range = (r_word_index < WI_W'(WORDS)) && (r_seq < 32'(FRAMES));
        is_last  = (r_word_index == WI_W'(WORDS - 1));
        for (int m = 0; m < ROW_FR; m++) begin
            in_lim[m] = NF_W'({r_seq[SEQ_W-1:2], 2'(m)}) < lim;
        end
        pair_inc = in_lim & (r_seq[1] ? 4'b1100 : 4'b0011);
        media_ok = in_range && (r_req_type == REQ_MEDIA)
                && (r_seq < 32'(r_n_frames)) && !fl_rdata.done[r_seq[1:0]];
        par2_ok  = in_range && (r_req_type != REQ_MEDIA)
                && (r_group_size == GS_PAIR) && !fl_rdata.pval[r_seq[1]];
        par4_ok  = in_range && (r_req_type != REQ_MEDIA)
                && (r_group_size == GS_QUAD) && !fl_rdata.qval;
        flag_wr  = is_last && (media_ok || par2_ok || par4_ok);

        done0 = fl_rdata.done
              | ((media_ok && is_last) ? (4'b0001 << r_seq[1:0]) : 4'b0000);
        pv0   = fl_rdata.pval | ((par2_ok && is_last) ? (2'b01 << r_seq[1]) : 2'b00);
        qv0   = fl_rdata.qval | (par4_ok && is_last);

        pair_chk      = rec_check(pv0[r_seq[1]], pair_inc, done0);
        pair_chk.fire = pair_chk.fire && is_last && (media_ok || par2_ok);
        done1 = done0 | (pair_chk.fire ? (4'b0001 << pair_chk.miss_off) : 4'b0000);
        quad_chk      = rec_check(qv0, in_lim, done1);
        quad_chk.fire = quad_chk.fire && is_last && (media_ok || par4_ok);
        done2 = done1 | (quad_chk.fire ? (4'b0001 << quad_chk.miss_off) : 4'b0000);

        // recovery sequencer view
        cur_quad     = !r_slot_p.fire;
        cur          = cur_quad ? r_slot_q : r_slot_p;
        acc_in       = (r_rd_first ? pm_rdata : r_acc) ^ (r_rd_use ? fm_rdata : 64'd0);
        acc_sel_last = (r_j == J_W'(ROW_FR));
        rec_word_end = acc_sel_last && (r_w == WI_W'(WORDS - 1));
        rec_last     = rec_word_end && (cur_quad || !r_slot_q.fire);
    end

    // ---- next state ---------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_cnt == ROW_W'(ROWS - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (start) n_state = ST_LOOK;
            end
            ST_LOOK: begin
                n_state = (pair_chk.fire || quad_chk.fire) ? ST_REC : ST_IDLE;
            end
            ST_REC: begin
                if (rec_last) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ---- datapath and memory control ----------------------------------------
    always_comb begin
        fl_we      = 1'b0;
        fl_waddr   = r_seq[SEQ_W-1:2];
        fl_wdata   = '0;
        fm_cmd     = '0;
        fm_wdata   = r_payload_word;
        pm_cmd     = '0;
        n_slot_p   = r_slot_p;
        n_slot_q   = r_slot_q;
        n_row      = r_row;
        n_half     = r_half;
        n_w        = r_w;
        n_j        = r_j;
        n_acc      = r_acc;
        n_rd_act   = 1'b0;
        n_rd_first = 1'b0;
        n_rd_use   = 1'b0;
        n_out_vld  = 1'b0;
        n_out_seq  = r_out_seq;
        n_out_idx  = r_out_idx;
        n_out_word = r_out_word;
        n_out_rec  = r_out_rec;
        n_out_last = r_out_last;

        case (r_state)
            ST_CLEAR: begin
                fl_we    = 1'b1;
                fl_waddr = r_clr_cnt;
            end
            ST_LOOK: begin
                fl_we         = flag_wr;
                fl_wdata.done = done2;
                fl_wdata.pval = pv0;
                fl_wdata.qval = qv0;
                fm_cmd.we     = media_ok;
                fm_cmd.wid    = r_seq[SEQ_W-1:0];
                fm_cmd.wword  = r_word_index;
                pm_cmd.we     = par2_ok || par4_ok;
                pm_cmd.wquad  = par4_ok;
                pm_cmd.wgrp   = par4_ok ? PG_W'(r_seq[SEQ_W-1:2]) : r_seq[SEQ_W-1:1];
                pm_cmd.wword  = r_word_index;
                n_out_vld     = media_ok;
                n_out_seq     = r_seq[SEQ_W-1:0];
                n_out_idx     = r_word_index;
                n_out_word    = r_payload_word;
                n_out_rec     = 1'b0;
                n_out_last    = !(pair_chk.fire || quad_chk.fire);
                n_slot_p      = pair_chk;
                n_slot_q      = quad_chk;
                n_row         = r_seq[SEQ_W-1:2];
                n_half        = r_seq[1];
                n_w           = '0;
                n_j           = '0;
            end
            ST_REC: begin
                if (r_rd_act) n_acc = acc_in;
                if (!acc_sel_last) begin
                    // one frame read per cycle over the row, parity on the first
                    fm_cmd.re    = 1'b1;
                    fm_cmd.rid   = {r_row, r_j[1:0]};
                    fm_cmd.rword = r_w;
                    pm_cmd.re    = (r_j == '0);
                    pm_cmd.rquad = cur_quad;
                    pm_cmd.rgrp  = cur_quad ? PG_W'(r_row) : {r_row, r_half};
                    pm_cmd.rword = r_w;
                    n_rd_act     = 1'b1;
                    n_rd_first   = (r_j == '0);
                    n_rd_use     = cur.use_mask[r_j[1:0]];
                    n_j          = r_j + 1'b1;
                end else begin
                    fm_cmd.we    = 1'b1;
                    fm_cmd.wid   = {r_row, cur.miss_off};
                    fm_cmd.wword = r_w;
                    fm_wdata     = acc_in;
                    n_out_vld    = 1'b1;
                    n_out_seq    = {r_row, cur.miss_off};
                    n_out_idx    = r_w;
                    n_out_word   = acc_in;
                    n_out_rec    = 1'b1;
                    n_out_last   = rec_last;
                    n_j          = '0;
                    if (r_w == WI_W'(WORDS - 1)) begin
                        n_w = '0;
                        if (cur_quad) n_slot_q.fire = 1'b0;
                        else          n_slot_p.fire = 1'b0;
                    end else begin
                        n_w = r_w + 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // ---- registers ----------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_cnt  <= '0;
            r_n_frames <= NF_RESET;
            r_out_vld  <= 1'b0;
            r_rd_act   <= 1'b0;
            r_slot_p   <= '0;
            r_slot_q   <= '0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            r_rd_act  <= n_rd_act;
            r_slot_p  <= n_slot_p;
            r_slot_q  <= n_slot_q;
            if (r_state == ST_CLEAR) r_clr_cnt <= r_clr_cnt + 1'b1;
            if (i_cfg_valid && o_cfg_ready) r_n_frames <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && start) begin
            r_req_type     <= i_req_type;
            r_seq          <= i_seq;
            r_group_size   <= i_group_size;
            r_word_index   <= i_word_index;
            r_payload_word <= i_payload_word;
        end
        r_row      <= n_row;
        r_half     <= n_half;
        r_w        <= n_w;
        r_j        <= n_j;
        r_acc      <= n_acc;
        r_rd_first <= n_rd_first;
        r_rd_use   <= n_rd_use;
        r_out_seq  <= n_out_seq;
        r_out_idx  <= n_out_idx;
        r_out_word <= n_out_word;
        r_out_rec  <= n_out_rec;
        r_out_last <= n_out_last;
    end

    assign o_result_valid   = r_out_vld;
    assign o_frame_seq      = r_out_seq;
    assign o_out_word_index = r_out_idx;
    assign o_out_word       = r_out_word;
    assign o_was_recovered  = r_out_rec;
    assign o_last_of_run    = r_out_last;

    // ---- stores ---------------------------------------------------------------
    xpf_flag_mem u_flag_mem (
        .i_clk   (i_clk),
        .i_we    (fl_we),
        .i_waddr (fl_waddr),
        .i_wdata (fl_wdata),
        .i_raddr (i_seq[SEQ_W-1:2]),
        .o_rdata (fl_rdata)
    );

    xpf_frame_mem u_frame_mem (
        .i_clk   (i_clk),
        .i_cmd   (fm_cmd),
        .i_wdata (fm_wdata),
        .o_rdata (fm_rdata)
    );

    xpf_parity_mem u_parity_mem (
        .i_clk   (i_clk),
        .i_cmd   (pm_cmd),
        .i_wdata (r_payload_word),
        .o_rdata (pm_rdata)
    );

    // ---- checks ---------------------------------------------------------------
    a_rec_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_REC) |-> (r_slot_p.fire || r_slot_q.fire))
        else $error("recovery running with no pending group");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(fm_cmd.we && fm_cmd.re && fm_cmd.wid == fm_cmd.rid
          && fm_cmd.wword == fm_cmd.rword))
        else $error("frame store read and write to one word together");

    a_gap_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_last_of_run) |=> !o_result_valid)
        else $error("result directly after end of run");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_out_word_index < WI_W'(WORDS)))
        else $error("word index out of range on result");

endmodule

@@ src/xpf_flag_mem.sv @@
// ----------------------------------------------------------------------------
// xpf_flag_mem
// Per-quad flag rows: delivered marks and parity valid marks.
// ----------------------------------------------------------------------------
module xpf_flag_mem
    import xpf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [ROW_W-1:0] i_waddr,
    input  t_flag_row        i_wdata,
    input  logic [ROW_W-1:0] i_raddr,
    output t_flag_row        o_rdata
);

    t_flag_row mem [ROWS];
    t_flag_row r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/xpf_frame_mem.sv @@
// ----------------------------------------------------------------------------
// xpf_frame_mem
// Frame payload store, addressed by frame number and word index.
// ----------------------------------------------------------------------------
module xpf_frame_mem
    import xpf_pkg::*;
(
    input  logic        i_clk,
    input  t_fm_cmd     i_cmd,
    input  logic [63:0] i_wdata,
    output logic [63:0] o_rdata
);

    logic [63:0]     mem [FRAMES * WORDS];
    logic [63:0]     r_rdata;
    logic [FA_W-1:0] waddr;
    logic [FA_W-1:0] raddr;

    assign waddr = FA_W'(FA_W'(i_cmd.wid) * FA_W'(WORDS)) + FA_W'(i_cmd.wword);
    assign raddr = FA_W'(FA_W'(i_cmd.rid) * FA_W'(WORDS)) + FA_W'(i_cmd.rword);

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            mem[waddr] <= i_wdata;
        end
        if (i_cmd.re) begin
            r_rdata <= mem[raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/xpf_parity_mem.sv @@
// ----------------------------------------------------------------------------
// xpf_parity_mem
// Pair and quad parity stores, one read and one write per cycle.
// ----------------------------------------------------------------------------
module xpf_parity_mem
    import xpf_pkg::*;
(
    input  logic        i_clk,
    input  t_pm_cmd     i_cmd,
    input  logic [63:0] i_wdata,
    output logic [63:0] o_rdata
);

    logic [63:0]     pmem [PAIRS * WORDS];
    logic [63:0]     qmem [QUADS * WORDS];
    logic [63:0]     r_pdata;
    logic [63:0]     r_qdata;
    logic            r_rquad;
    logic [PA_W-1:0] pw_addr;
    logic [PA_W-1:0] pr_addr;
    logic [QA_W-1:0] qw_addr;
    logic [QA_W-1:0] qr_addr;

    assign pw_addr = PA_W'(PA_W'(i_cmd.wgrp) * PA_W'(WORDS)) + PA_W'(i_cmd.wword);
    assign pr_addr = PA_W'(PA_W'(i_cmd.rgrp) * PA_W'(WORDS)) + PA_W'(i_cmd.rword);
    assign qw_addr = QA_W'(QA_W'(i_cmd.wgrp[QG_W-1:0]) * QA_W'(WORDS))
                   + QA_W'(i_cmd.wword);
    assign qr_addr = QA_W'(QA_W'(i_cmd.rgrp[QG_W-1:0]) * QA_W'(WORDS))
                   + QA_W'(i_cmd.rword);

    always_ff @(posedge i_clk) begin
        if (i_cmd.we && !i_cmd.wquad) begin
            pmem[pw_addr] <= i_wdata;
        end
        if (i_cmd.we && i_cmd.wquad) begin
            qmem[qw_addr] <= i_wdata;
        end
        if (i_cmd.re) begin
            r_pdata <= pmem[pr_addr];
            r_qdata <= qmem[qr_addr];
            r_rquad <= i_cmd.rquad;
        end
    end

    assign o_rdata = r_rquad ? r_qdata : r_pdata;

endmodule

@@ tb/xor_parity_fec_recovery_core_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xor_parity_fec_recovery_core_test
// Self-checking bench for the XOR parity recovery core. Complete media frames
// and pair/quad parity packets are sent in shuffled order, with ignored
// words mixed in. An in-bench predictor keeps its own frame and parity stores
// and queues the expected delivered and rebuilt words; the monitor checks each
// result strobe against the oldest expected word. n_frames is changed between
// phases while the core is idle.
// ----------------------------------------------------------------------------
module xor_parity_fec_recovery_core_test;
    import xpf_pkg::*;

    localparam int DRAIN_CYC = 300;    // two rebuilt frames plus margin

    typedef struct {
        logic        typ;
        logic [31:0] seq;
        logic [7:0]  gsz;
        logic [4:0]  idx;
        logic [63:0] data;
    } t_word_req;

    typedef struct {
        logic [SEQ_W-1:0] fseq;
        logic [WI_W-1:0]  widx;
        logic [63:0]      word;
        logic             rec;
        logic             last;
    } t_out_word;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic              i_req_type = 1'b0;
    logic [31:0]       i_seq = '0;
    logic [7:0]        i_group_size = '0;
    logic [WI_W-1:0]   i_word_index = '0;
    logic [63:0]       i_payload_word = '0;
    logic              o_result_valid;
    logic [SEQ_W-1:0]  o_frame_seq;
    logic [WI_W-1:0]   o_out_word_index;
    logic [63:0]       o_out_word;
    logic              o_was_recovered;
    logic              o_last_of_run;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [NF_W-1:0]   i_cfg_data = '0;

    xor_parity_fec_recovery_core i_dut (.*);

    // ------------------------------------------------------------------------
    // predictor state: own copy of stores, flags and n_frames
    // ------------------------------------------------------------------------
    logic [63:0] frm_mem [FRAMES*WORDS];
    bit          frm_rcvd [FRAMES];
    bit          frm_done [FRAMES];
    logic [63:0] pair_mem [PAIRS*WORDS];
    bit          pair_ok [PAIRS];
    logic [63:0] quad_mem [QUADS*WORDS];
    bit          quad_ok [QUADS];
    int          n_frames_m = 1024;

    t_word_req   word_q[$];       // words waiting to be sent
    t_out_word   delivery_q[$];   // words the core should deliver
    int          done_list[$];    // delivered frames, for ignored-word noise
    int          idle_pct = 0;
    int          errors = 0;

    always #1 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        errors++;
    endtask

    // rebuild the single missing frame of a group, if there is exactly one
    task automatic try_rebuild(input bit quad, input int grp);
        int k, base, e, lim, miss, misses;
        logic [63:0] acc;
        k = quad ? 4 : 2;
        if (quad ? !quad_ok[grp] : !pair_ok[grp])
            return;
        base = grp * k;
        e = base + k;
        lim = (n_frames_m < FRAMES) ? n_frames_m : FRAMES;
        if (e > lim)
            e = lim;
        misses = 0;
        miss = 0;
        for (int i = base; i < e; i++) begin
            if (!frm_rcvd[i]) begin
                miss = i;
                misses++;
            end
        end
        if (misses != 1 || frm_done[miss])
            return;
        for (int w = 0; w < WORDS; w++) begin
            acc = quad ? quad_mem[grp*WORDS+w] : pair_mem[grp*WORDS+w];
            for (int i = base; i < e; i++)
                if (i != miss)
                    acc ^= frm_mem[i*WORDS+w];
            frm_mem[miss*WORDS+w] = acc;
            delivery_q.push_back('{miss[SEQ_W-1:0], w[WI_W-1:0], acc, 1'b1, 1'b0});
        end
        frm_rcvd[miss] = 1'b1;
        frm_done[miss] = 1'b1;
        done_list.push_back(miss);
    endtask

    // work out what one accepted word causes
    task automatic predict_word(input t_word_req r);
        int  n0, g;
        bit  last;
        n0 = delivery_q.size();
        last = (r.idx == WORDS - 1);
        if (r.idx < WORDS) begin
            if (r.typ == REQ_MEDIA) begin
                if (!(r.seq >= n_frames_m || r.seq >= FRAMES || frm_done[r.seq])) begin
                    frm_mem[r.seq*WORDS+r.idx] = r.data;
                    delivery_q.push_back('{r.seq[SEQ_W-1:0], r.idx, r.data, 1'b0, 1'b0});
                    if (last) begin
                        frm_rcvd[r.seq] = 1'b1;
                        frm_done[r.seq] = 1'b1;
                        done_list.push_back(r.seq);
                        try_rebuild(1'b0, r.seq / 2);
                        try_rebuild(1'b1, r.seq / 4);
                    end
                end
            end else if (r.gsz == GS_PAIR) begin
                g = r.seq / 2;
                if (r.seq / 2 < PAIRS && !pair_ok[g]) begin
                    pair_mem[g*WORDS+r.idx] = r.data;
                    if (last) begin
                        pair_ok[g] = 1'b1;
                        try_rebuild(1'b0, g);
                    end
                end
            end else if (r.gsz == GS_QUAD) begin
                g = r.seq / 4;
                if (r.seq / 4 < QUADS && !quad_ok[g]) begin
                    quad_mem[g*WORDS+r.idx] = r.data;
                    if (last) begin
                        quad_ok[g] = 1'b1;
                        try_rebuild(1'b1, g);
                    end
                end
            end
        end
        if (delivery_q.size() > n0)
            delivery_q[$].last = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // driver: one word presented until start & !busy, then the next
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            bit taken;
            taken = start && !busy;
            if (taken) begin
                predict_word(word_q[0]);
                void'(word_q.pop_front());
            end
            if (start && !taken) begin
                // hold the word until it is taken
            end else if (word_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                start          <= 1'b1;
                i_req_type     <= word_q[0].typ;
                i_seq          <= word_q[0].seq;
                i_group_size   <= word_q[0].gsz;
                i_word_index   <= word_q[0].idx;
                i_payload_word <= word_q[0].data;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: the core cannot be stalled, every strobe is one word
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (delivery_q.size() == 0) begin
                report_mismatch($sformatf("unexpected word seq %0d idx %0d",
                                          o_frame_seq, o_out_word_index));
            end else begin
                t_out_word e;
                e = delivery_q.pop_front();
                if (o_frame_seq !== e.fseq)
                    report_mismatch($sformatf("frame_seq %0d, want %0d", o_frame_seq, e.fseq));
                if (o_out_word_index !== e.widx)
                    report_mismatch($sformatf("word_index %0d, want %0d",
                                              o_out_word_index, e.widx));
                if (o_out_word !== e.word)
                    report_mismatch($sformatf("word %h, want %h", o_out_word, e.word));
                if (o_was_recovered !== e.rec)
                    report_mismatch($sformatf("was_recovered %b, want %b",
                                              o_was_recovered, e.rec));
                if (o_last_of_run !== e.last)
                    report_mismatch($sformatf("last_of_run %b, want %b",
                                              o_last_of_run, e.last));
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_word(input logic typ, input logic [31:0] seq,
                             input logic [7:0] gsz, input logic [4:0] idx,
                             input logic [63:0] data);
        word_q.push_back('{typ, seq, gsz, idx, data});
    endtask

    task automatic push_packet(input logic typ, input int seq, input logic [7:0] gsz,
                               input logic [63:0] pay [WORDS]);
        for (int w = 0; w < WORDS; w++)
            push_word(typ, seq, gsz, w[4:0], pay[w]);
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    // one word the core must ignore
    task automatic push_noise();
        logic [7:0] g;
        case ($urandom_range(0, 4))
            0: push_word($urandom_range(0, 1), $urandom, 8'(GS_PAIR << $urandom_range(0, 1)),
                         5'($urandom_range(WORDS, 31)), rnd64());
            1: begin
                do g = 8'($urandom); while (g == GS_PAIR || g == GS_QUAD);
                push_word(1'b1, $urandom, g, 5'($urandom_range(0, WORDS - 1)), rnd64());
            end
            2: push_word(REQ_MEDIA, $urandom_range(FRAMES, 32'hFFFF_FFFF), 8'($urandom),
                         5'($urandom_range(0, WORDS - 1)), rnd64());
            3: push_word(1'b1, $urandom_range(FRAMES, 32'hFFFF_FFFF),
                         $urandom_range(0, 1) ? GS_PAIR : GS_QUAD,
                         5'($urandom_range(0, WORDS - 1)), rnd64());
            default: begin
                if (done_list.size() > 0)
                    push_word(REQ_MEDIA, done_list[$urandom_range(0, done_list.size() - 1)],
                              8'($urandom), 5'($urandom_range(0, WORDS - 1)), rnd64());
                else
                    push_word(REQ_MEDIA, 32'hFFFF_FFFF, 8'hFF, 5'd0, rnd64());
            end
        endcase
    endtask

    // a quad of fresh frames: one frame lost (pair parity only: other pair frames may also be lost),
    // pair and/or quad parity sent, all packets shuffled with ignored words between them
    task automatic push_group(input int qb);
        logic [63:0] pay [4][WORDS];
        logic [63:0] par [WORDS];
        int kind, miss, npk, tmp, j;
        int pk [8];    // 0..3 frame, 4/5 pair parity, 6 quad parity
        kind = $urandom_range(0, 2);
        miss = $urandom_range(0, 3);
        for (int f = 0; f < 4; f++)
            for (int w = 0; w < WORDS; w++)
                pay[f][w] = rnd64();
        npk = 0;
        for (int f = 0; f < 4; f++)
            if (f != miss && (kind != 1 || f / 2 == miss / 2 || $urandom_range(0, 1)))
                pk[npk++] = f;
        if (kind != 0)
            pk[npk++] = 4 + miss / 2;
        if (kind != 1)
            pk[npk++] = 6;
        for (int i = npk - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = pk[i]; pk[i] = pk[j]; pk[j] = tmp;
        end
        for (int i = 0; i < npk; i++) begin
            if (pk[i] < 4) begin
                push_packet(REQ_MEDIA, qb + pk[i], 8'($urandom), pay[pk[i]]);
            end else if (pk[i] < 6) begin
                for (int w = 0; w < WORDS; w++)
                    par[w] = pay[2*(pk[i]-4)][w] ^ pay[2*(pk[i]-4)+1][w];
                push_packet(1'b1, qb + 2*(pk[i]-4) + $urandom_range(0, 1), GS_PAIR, par);
            end else begin
                for (int w = 0; w < WORDS; w++)
                    par[w] = pay[0][w] ^ pay[1][w] ^ pay[2][w] ^ pay[3][w];
                push_packet(1'b1, qb + $urandom_range(0, 3), GS_QUAD, par);
            end
            if ($urandom_range(0, 99) < 30)
                push_noise();
        end
        // a stray parity word for the first pair or the quad, dropped if that group has its parity
        if ($urandom_range(0, 99) < 25)
            push_word(1'b1, qb, kind == 1 ? GS_PAIR : GS_QUAD,
                      5'($urandom_range(0, WORDS - 1)), rnd64());
    endtask

    task automatic wait_idle();
        while (word_q.size() > 0 || delivery_q.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic write_n_frames(input int v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= NF_W'(v);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        n_frames_m = v;
    endtask

    // ------------------------------------------------------------------------
    // run: phases with different n_frames and idling
    // ------------------------------------------------------------------------
    initial begin
        logic [63:0] pay [WORDS];
        int next_quad;
        next_quad = 2;     // frames 0..7 kept for the clipped-session phase
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes and ignored words, no idling
        write_n_frames(1024);
        push_word(REQ_MEDIA, 1023, 8'h00, 5'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        push_word(REQ_MEDIA, 1023, 8'hFF, 5'd1, 64'h0);
        push_word(REQ_MEDIA, 32'hFFFF_FFFF, 8'hFF, 5'd19, 64'hFFFF_FFFF_FFFF_FFFF);
        push_word(REQ_MEDIA, 1024, 8'h02, 5'd3, 64'h0123_4567_89AB_CDEF);
        push_word(REQ_MEDIA, 0, 8'h00, 5'd31, 64'hFFFF_FFFF_FFFF_FFFF);
        push_word(REQ_MEDIA, 0, 8'h00, 5'd20, 64'h0);
        push_word(1'b1, 0, 8'h00, 5'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        push_word(1'b1, 0, 8'hFF, 5'd19, 64'hFFFF_FFFF_FFFF_FFFF);
        push_word(1'b1, 0, 8'h03, 5'd5, 64'h0);
        push_word(1'b1, 32'hFFFF_FFFF, GS_PAIR, 5'd19, 64'h0);
        push_word(1'b1, 32'hFFFF_FFFF, GS_QUAD, 5'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        push_word(1'b1, 1024, GS_QUAD, 5'd19, 64'h0);
        wait_idle();

        // full session, sender mostly idle
        idle_pct = 80;
        repeat (2) begin
            push_group(4 * next_quad);
            next_quad++;
        end
        wait_idle();

        // empty session: every frame ignored, parity still taken
        write_n_frames(0);
        idle_pct = 21;
        for (int w = 0; w < WORDS; w++) pay[w] = rnd64();
        push_packet(1'b1, 1020, GS_QUAD, pay);
        push_packet(REQ_MEDIA, 0, 8'h00, pay);
        repeat (4) push_noise();
        wait_idle();

        // six-frame session: quad 1 clipped to frames 4 and 5
        write_n_frames(6);
        for (int w = 0; w < WORDS; w++) pay[w] = rnd64();
        push_packet(REQ_MEDIA, 4, 8'h00, pay);
        for (int w = 0; w < WORDS; w++) pay[w] = rnd64();
        push_packet(1'b1, 7, GS_QUAD, pay);
        for (int w = 0; w < WORDS; w++) pay[w] = rnd64();
        push_packet(1'b1, 0, GS_PAIR, pay);
        push_packet(REQ_MEDIA, 1, 8'h00, pay);
        push_packet(REQ_MEDIA, 6, 8'h00, pay);
        wait_idle();

        // back to the full session; quad 255 parity from the empty session
        write_n_frames(1024);
        idle_pct = 0;
        for (int f = 1020; f < 1023; f++) begin
            for (int w = 0; w < WORDS; w++) pay[w] = rnd64();
            push_packet(REQ_MEDIA, f, 8'($urandom), pay);
        end
        repeat (2) begin
            push_group(4 * next_quad);
            next_quad++;
        end
        wait_idle();

        // receiver stall phase has nothing to stall; sender idles at 21
        idle_pct = 21;
        repeat (3) begin
            push_group(4 * next_quad);
            next_quad++;
        end
        wait_idle();

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ filelist.f @@
src/xpf_pkg.sv
src/xpf_flag_mem.sv
src/xpf_frame_mem.sv
src/xpf_parity_mem.sv
src/xor_parity_fec_recovery_core.sv
tb/xor_parity_fec_recovery_core_test.sv
